FILE: sv/kwdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed watchdog timer package
// Commands, register offsets, key values, control bits and payload types.
// ----------------------------------------------------------------------------
package kwdt_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CMD_W  = 2;
    localparam int unsigned IDX_W  = 3;

    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    localparam logic [IDX_W-1:0] REG_CTRL   = 3'd0;
    localparam logic [IDX_W-1:0] REG_LOAD   = 3'd1;
    localparam logic [IDX_W-1:0] REG_COUNT  = 3'd2;
    localparam logic [IDX_W-1:0] REG_STATUS = 3'd3;
    localparam logic [IDX_W-1:0] REG_KEY    = 3'd4;

    localparam logic [DATA_W-1:0] KICK_CODE      = 32'h5A5A_5A5A;
    localparam logic [DATA_W-1:0] FREEZE_CODE    = 32'h1ACC_E551;
    localparam logic [DATA_W-1:0] RELOAD_DEFAULT = 32'h0000_FFFF;
    localparam logic [DATA_W-1:0] COUNT_MAX      = 32'hFFFF_FFFF;

    localparam int unsigned CTRL_EN    = 0;
    localparam int unsigned CTRL_INTEN = 1;
    localparam int unsigned CTRL_RSTEN = 2;
    localparam int unsigned CTRL_LOCK  = 3;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [IDX_W-1:0]  register_index;
        logic [DATA_W-1:0] write_data;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_level;
        logic              reset_request;
        logic              timeout_status;
    } t_result;

endpackage

FILE: sv/kwdt_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed watchdog item channel
// Valid/ready channel carrying one bus access or counter tick per transfer.
// ----------------------------------------------------------------------------
interface kwdt_item_if import kwdt_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  register_index;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output command, output register_index,
                    output write_data, input ready);
    modport sink   (input valid, input command, input register_index,
                    input write_data, output ready);

endinterface

FILE: sv/kwdt_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed watchdog result channel
// Valid/ready channel carrying one result per accepted item.
// ----------------------------------------------------------------------------
interface kwdt_result_if import kwdt_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              irq_level;
    logic              reset_request;
    logic              timeout_status;

    modport source (output valid, output read_data, output irq_level,
                    output reset_request, output timeout_status, input ready);
    modport sink   (input valid, input read_data, input irq_level,
                    input reset_request, input timeout_status, output ready);

endinterface

FILE: sv/kwdt_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed watchdog input register
// Captures one item per transfer and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module kwdt_in_stage import kwdt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kwdt_item_if.sink   i_item,
    input  logic        i_advance,
    output logic        o_valid,
    output t_item       o_item
);

    logic  r_valid;
    t_item r_item;

    // take a new item when empty or when the held one moves on this cycle
    assign i_item.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_item.command        <= i_item.command;
            r_item.register_index <= i_item.register_index;
            r_item.write_data     <= i_item.write_data;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: sv/kwdt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed watchdog register core
// Holds control, reload, count and flags; works out one result per item.
// ----------------------------------------------------------------------------
module kwdt_core import kwdt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    logic [DATA_W-1:0] r_ctrl,    n_ctrl;
    logic [DATA_W-1:0] r_reload,  n_reload;
    logic [DATA_W-1:0] r_elapsed, n_elapsed;
    logic              r_timeout, n_timeout;
    logic              r_armed,   n_armed;
    logic              r_irq,     n_irq;

    logic              en;
    logic              locked;
    logic [DATA_W-1:0] inc;
    logic [DATA_W-1:0] countdown;
    logic [DATA_W-1:0] rdata;
    logic              rst_req;

    assign en     = r_ctrl[CTRL_EN];
    assign locked = r_ctrl[CTRL_LOCK];
    // saturate at all ones
    assign inc    = (r_elapsed == COUNT_MAX) ? r_elapsed : r_elapsed + 1'b1;

    always_comb begin
        if (!en) begin
            countdown = r_reload;
        end else if (r_elapsed >= r_reload) begin
            countdown = '0;
        end else begin
            countdown = r_reload - r_elapsed;
        end
    end

    always_comb begin
        n_ctrl    = r_ctrl;
        n_reload  = r_reload;
        n_elapsed = r_elapsed;
        n_timeout = r_timeout;
        n_armed   = r_armed;
        n_irq     = r_irq;
        rdata     = '0;
        rst_req   = 1'b0;
        case (i_item.command)
            CMD_READ: begin
                case (i_item.register_index)
                    REG_CTRL:   rdata = r_ctrl;
                    REG_LOAD:   rdata = r_reload;
                    REG_COUNT:  rdata = countdown;
                    REG_STATUS: rdata = {{(DATA_W-1){1'b0}}, r_timeout};
                    default:    rdata = '0;
                endcase
            end
            CMD_WRITE: begin
                case (i_item.register_index)
                    REG_CTRL: begin
                        if (!locked) begin
                            n_ctrl            = i_item.write_data;
                            n_ctrl[CTRL_LOCK] = 1'b0;
                            n_armed           = i_item.write_data[CTRL_EN];
                            if (i_item.write_data[CTRL_EN]) begin
                                n_elapsed = '0;
                            end
                        end
                    end
                    REG_LOAD: begin
                        if (!locked) begin
                            n_reload = i_item.write_data;
                            // re-arm without restarting the count
                            if (en) begin
                                n_armed = 1'b1;
                            end
                        end
                    end
                    REG_STATUS: begin
                        if (i_item.write_data[0]) begin
                            n_timeout = 1'b0;
                        end
                    end
                    REG_KEY: begin
                        if (i_item.write_data == KICK_CODE) begin
                            n_timeout = 1'b0;
                            n_irq     = 1'b0;
                            n_elapsed = '0;
                            n_armed   = en;
                        end else if (i_item.write_data == FREEZE_CODE) begin
                            n_ctrl[CTRL_LOCK] = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            CMD_TICK: begin
                if (en) begin
                    n_elapsed = inc;
                    if (r_armed && (inc >= r_reload)) begin
                        n_armed   = 1'b0;
                        n_timeout = 1'b1;
                        if (r_ctrl[CTRL_INTEN]) begin
                            n_irq = 1'b1;
                        end
                        rst_req = r_ctrl[CTRL_RSTEN];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl    <= '0;
            r_reload  <= RELOAD_DEFAULT;
            r_elapsed <= '0;
            r_timeout <= 1'b0;
            r_armed   <= 1'b0;
            r_irq     <= 1'b0;
        end else if (i_fire) begin
            r_ctrl    <= n_ctrl;
            r_reload  <= n_reload;
            r_elapsed <= n_elapsed;
            r_timeout <= n_timeout;
            r_armed   <= n_armed;
            r_irq     <= n_irq;
        end
    end

    assign o_result.read_data      = rdata;
    assign o_result.irq_level      = n_irq;
    assign o_result.reset_request  = rst_req;
    assign o_result.timeout_status = n_timeout;

endmodule

FILE: sv/kwdt_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed watchdog result register
// Holds one result until its transfer; reloads in the same cycle it drains.
// ----------------------------------------------------------------------------
module kwdt_out_stage import kwdt_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  t_result       i_result,
    output logic          o_space,
    kwdt_result_if.source o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_space = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_result.valid          = r_valid;
    assign o_result.read_data      = r_result.read_data;
    assign o_result.irq_level      = r_result.irq_level;
    assign o_result.reset_request  = r_result.reset_request;
    assign o_result.timeout_status = r_result.timeout_status;

endmodule

FILE: sv/keyed_watchdog_timer_unit.sv
`timescale 1ns / 1ps
// Path: an item transfer is captured in the input register, its result in the result register.
// Throughput: one item per cycle while the result sink is ready; the state update is
// one increment and compare between the input register and the result register.
// Reset: synchronous, active low; both channels empty, control and count cleared,
// reload set to 0x0000FFFF. No clearing pass; items are taken from the first cycle.
// ----------------------------------------------------------------------------
// Keyed watchdog timer unit
// Five-register watchdog with feed and lock keys, fed by bus accesses and ticks.
// ----------------------------------------------------------------------------
module keyed_watchdog_timer_unit import kwdt_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kwdt_item_if.sink     i_item,
    kwdt_result_if.source o_result
);

    logic    in_valid;
    t_item   in_item;
    logic    out_space;
    logic    advance;
    t_result core_result;

    // move the held item into the result register, updating state
    assign advance = in_valid && out_space;

    kwdt_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    kwdt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (in_item),
        .o_result (core_result)
    );

    kwdt_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (core_result),
        .o_space  (out_space),
        .o_result (o_result)
    );

endmodule

FILE: sv/kwdt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed watchdog port checker
// Watches the top-level channels over time; bound to the top level below.
// ----------------------------------------------------------------------------
module kwdt_checker import kwdt_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [DATA_W-1:0] i_read_data,
    input logic              i_irq_level,
    input logic              i_reset_request,
    input logic              i_timeout_status
);

    // an expiry always leaves the timeout flag set in the same result
    a_rst_sets_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_reset_request) |-> i_timeout_status)
        else $error("reset request without timeout flag");

    // nothing comes out right after reset
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result presented straight after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_read_data) && $stable(i_irq_level) &&
             $stable(i_reset_request) && $stable(i_timeout_status)))
        else $error("result changed while stalled");

endmodule

bind keyed_watchdog_timer_unit kwdt_checker u_kwdt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_read_data      (o_result.read_data),
    .i_irq_level      (o_result.irq_level),
    .i_reset_request  (o_result.reset_request),
    .i_timeout_status (o_result.timeout_status)
);
